// ----- src/bencode_stream_tokenizer_assert.svh -----
// Assertion macros shared by the tokenizer RTL.
`ifndef BENCODE_STREAM_TOKENIZER_ASSERT_SVH
`define BENCODE_STREAM_TOKENIZER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BST_ASSERT_IMPL(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("tokenizer check failed: same-cycle implication");

// Next-cycle implication, disabled while reset is asserted.
`define BST_ASSERT_NEXT(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("tokenizer check failed: next-cycle implication");

`endif

// ----- src/bst_pkg.sv -----
// Types and constants of the bencode stream tokenizer.
package bst_pkg;

  localparam int unsigned DEPTH_W = 6;
  localparam int unsigned VALUE_W = 64;

  // Parser modes (plain state codes).
  localparam logic [2:0] MODE_EXPECT  = 3'd0;
  localparam logic [2:0] MODE_INT     = 3'd1;
  localparam logic [2:0] MODE_STRLEN  = 3'd2;
  localparam logic [2:0] MODE_STRDATA = 3'd3;
  localparam logic [2:0] MODE_DONE    = 3'd4;

  // Event codes.
  localparam logic [2:0] EV_NONE  = 3'd0;
  localparam logic [2:0] EV_INT   = 3'd1;
  localparam logic [2:0] EV_HDR   = 3'd2;
  localparam logic [2:0] EV_BYTE  = 3'd3;
  localparam logic [2:0] EV_LOPEN = 3'd4;
  localparam logic [2:0] EV_DOPEN = 3'd5;
  localparam logic [2:0] EV_CLOSE = 3'd6;
  localparam logic [2:0] EV_ERR   = 3'd7;

  // Error codes.
  localparam logic [3:0] ERR_NONE     = 4'd0;
  localparam logic [3:0] ERR_BAD_TYPE = 4'd1;
  localparam logic [3:0] ERR_BAD_INT  = 4'd2;
  localparam logic [3:0] ERR_INT_RNG  = 4'd3;
  localparam logic [3:0] ERR_BAD_LEN  = 4'd4;
  localparam logic [3:0] ERR_KEY_TYPE = 4'd5;
  localparam logic [3:0] ERR_TOO_DEEP = 4'd6;
  localparam logic [3:0] ERR_EARLY    = 4'd7;
  localparam logic [3:0] ERR_TRAILING = 4'd8;

  // Container stack entries: bit 0 marks a dict, bit 1 a pending value.
  localparam logic [1:0] ENT_LIST     = 2'd0;
  localparam logic [1:0] ENT_DICT_KEY = 2'd1;
  localparam logic [1:0] ENT_DICT_VAL = 2'd3;

  // Syntax characters.
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_I     = 8'h69;
  localparam logic [7:0] CH_E     = 8'h65;
  localparam logic [7:0] CH_L     = 8'h6C;
  localparam logic [7:0] CH_D     = 8'h64;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_MINUS = 8'h2D;

  localparam logic [63:0] POS_LIMIT = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] NEG_LIMIT = 64'h8000_0000_0000_0000;

  typedef struct packed {
    logic [2:0]         mode;
    logic [63:0]        acc;
    logic               neg;
    logic               seen;
    logic [62:0]        rem;
    logic [DEPTH_W-1:0] depth;
    logic [1:0]         top;
    logic               top_done;
    logic [3:0]         err;
  } state_t;

  typedef struct packed {
    logic [2:0]                event_res;
    logic signed [VALUE_W-1:0] value;
    logic [DEPTH_W-1:0]        nest_depth;
    logic                      is_key;
    logic [3:0]                error_code;
    logic                      message_ok;
  } result_t;

  localparam state_t ST_RESET = '{mode: MODE_EXPECT, default: '0};

endpackage

// ----- src/bst_if.sv -----
// Stream channel interfaces: raw byte input and token result output.
interface bst_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface bst_out_if;
  import bst_pkg::*;
  logic                      valid;
  logic                      ready;
  logic [2:0]                event_res;
  logic signed [VALUE_W-1:0] value;
  logic [DEPTH_W-1:0]        nest_depth;
  logic                      is_key;
  logic [3:0]                error_code;
  logic                      message_ok;

  modport source (output valid, output event_res, output value, output nest_depth,
                  output is_key, output error_code, output message_ok, input ready);
  modport sink   (input valid, input event_res, input value, input nest_depth,
                  input is_key, input error_code, input message_ok, output ready);
endinterface

// ----- src/bencode_stream_tokenizer.sv -----
// Top level of the streaming bencode tokenizer.
//
// Usage:
//   in_i carries one message byte per transaction (data_byte) and a flag
//   (last_byte) on the final byte of each message. out_o returns exactly one
//   token per input byte: event_res, value, nest_depth, is_key, error_code
//   and message_ok. Both channels use a valid/ready handshake.
// Pipeline: a byte accepted into the input register is parsed from there and
//   its token is loaded into the output register, which drives out_o; while
//   out_o stalls, the byte waits in the input register in between.
// Throughput: 1 byte per cycle, sustained while out_o takes every token. The
//   limit is the parser state update (the x10 accumulator with its overflow
//   compare and the container stack push/pop), which feeds back through st_q.
// Stall: when out_o is not taken, the token holds in the output register and
//   one more byte is held in the input register; in_i then drops ready.
// Reset: rst_ni clears the parser state and both valid flags. The container
//   stack is not cleared; only entries pushed since are ever read. An error
//   stays latched until the last byte of the message, after which the parser
//   returns to its reset state on its own.
module bencode_stream_tokenizer #(
  parameter int unsigned MAX_DEPTH = 32
) (
  input logic      clk_i,
  input logic      rst_ni,
  bst_in_if.sink   in_i,
  bst_out_if.source out_o
);
  import bst_pkg::*;

  localparam int unsigned IdxW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;

  // Input register.
  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       in_last_q;

  // Parser state and container stack (entries below the cached top).
  state_t     st_q;
  state_t     st_d;
  logic [1:0] stack_q [MAX_DEPTH];

  // Output register.
  logic       out_valid_q;
  result_t    res_q;
  result_t    res_d;

  logic               advance;
  logic               push;
  logic [DEPTH_W-1:0] depth_m1;
  logic [DEPTH_W-1:0] depth_m2;
  logic [IdxW-1:0]    top_idx;
  logic [IdxW-1:0]    below_idx;
  logic [1:0]         below;

  // Process the held byte when the output register is free or being drained.
  assign advance    = in_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !in_valid_q || advance;

  assign depth_m1  = st_q.depth - 6'd1;
  assign depth_m2  = st_q.depth - 6'd2;
  assign top_idx   = depth_m1[IdxW-1:0];
  assign below_idx = depth_m2[IdxW-1:0];
  // Entry that becomes the top on a close; only used at depth two and above.
  assign below     = stack_q[below_idx];

  bst_step #(
    .MAX_DEPTH (MAX_DEPTH)
  ) u_step (
    .cur_i   (st_q),
    .byte_i  (in_byte_q),
    .last_i  (in_last_q),
    .below_i (below),
    .nxt_o   (st_d),
    .res_o   (res_d),
    .push_o  (push)
  );

  // Capture a new byte whenever the input register frees up.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      in_byte_q <= in_i.data_byte;
      in_last_q <= in_i.last_byte;
    end
  end

  // Advance the parser state once per processed byte.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_RESET;
    end else if (advance) begin
      st_q <= st_d;
    end
  end

  // On an open, spill the old top entry into the stack.
  always_ff @(posedge clk_i) begin
    if (advance && push && st_q.depth != '0) begin
      stack_q[top_idx] <= st_q.top;
    end
  end

  // Output register: load on advance, drop valid once taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.event_res  = res_q.event_res;
  assign out_o.value      = res_q.value;
  assign out_o.nest_depth = res_q.nest_depth;
  assign out_o.is_key     = res_q.is_key;
  assign out_o.error_code = res_q.error_code;
  assign out_o.message_ok = res_q.message_ok;

  // Assertions.
`include "bencode_stream_tokenizer_assert.svh"

  `BST_ASSERT_IMPL(a_depth_bound, clk_i, rst_ni, 1'b1, st_q.depth <= DEPTH_W'(MAX_DEPTH))
  `BST_ASSERT_NEXT(a_last_resets, clk_i, rst_ni, advance && in_last_q, (st_q.depth == '0) && (st_q.err == ERR_NONE) && !st_q.top_done)
  `BST_ASSERT_IMPL(a_err_code_pairs, clk_i, rst_ni, out_valid_q, (res_q.event_res == EV_ERR) == (res_q.error_code != ERR_NONE))
  `BST_ASSERT_IMPL(a_ok_not_err, clk_i, rst_ni, out_valid_q && res_q.message_ok, res_q.event_res != EV_ERR)

endmodule

// ----- src/bst_step.sv -----
// Per-byte parser step: next state and token result from the current state.
module bst_step #(
  parameter int unsigned MAX_DEPTH = 32
) (
  input  bst_pkg::state_t  cur_i,
  input  logic [7:0]       byte_i,
  input  logic             last_i,
  input  logic [1:0]       below_i,
  output bst_pkg::state_t  nxt_o,
  output bst_pkg::result_t res_o,
  output logic             push_o
);
  import bst_pkg::*;

  logic        is_dig;
  logic [3:0]  dig;
  logic [67:0] acc10;
  logic [63:0] lim;
  logic        over_int;
  logic        over_len;
  logic        key_ctx;
  logic [1:0]  top_eff;
  logic [62:0] rem_dec;
  logic        finish;
  logic [2:0]  ev;
  logic [63:0] val;
  logic        key;
  logic        ok;
  state_t      nxt;
  logic [1:0]  new_entry;

  assign is_dig  = byte_i inside {[CH_0:CH_9]};
  assign dig     = byte_i[3:0];
  // acc * 10 + digit, with headroom for the overflow compare
  assign acc10   = {1'b0, cur_i.acc, 3'b000} + {3'b000, cur_i.acc, 1'b0} + {64'd0, dig};
  assign lim     = cur_i.neg ? NEG_LIMIT : POS_LIMIT;
  assign over_int = acc10 > {4'd0, lim};
  assign over_len = acc10 > {4'd0, POS_LIMIT};
  assign top_eff = (cur_i.depth == '0) ? ENT_LIST : cur_i.top;
  assign key_ctx = (cur_i.depth != '0) && (cur_i.top == ENT_DICT_KEY);
  assign rem_dec = (cur_i.rem != '0) ? cur_i.rem - 63'd1 : '0;

  always_comb begin
    nxt       = cur_i;
    ev        = EV_NONE;
    val       = '0;
    key       = 1'b0;
    finish    = 1'b0;
    push_o    = 1'b0;
    ok        = 1'b0;
    new_entry = (byte_i == CH_D) ? ENT_DICT_KEY : ENT_LIST;

    if (cur_i.err != ERR_NONE) begin
      ev = EV_ERR;
    end else if (cur_i.top_done || cur_i.mode == MODE_DONE) begin
      nxt.err = ERR_TRAILING;
      ev      = EV_ERR;
    end else begin
      case (cur_i.mode)
        MODE_EXPECT: begin
          if (byte_i == CH_E) begin
            if (cur_i.depth != '0 && top_eff != ENT_DICT_VAL) begin
              // pop, then the closed container counts as a finished value
              ev        = EV_CLOSE;
              nxt.depth = cur_i.depth - 6'd1;
              if (nxt.depth == '0) begin
                nxt.top_done = 1'b1;
                nxt.mode     = MODE_DONE;
              end else begin
                nxt.top  = {below_i[1] ^ below_i[0], below_i[0]};
                nxt.mode = MODE_EXPECT;
              end
            end else begin
              nxt.err = ERR_BAD_TYPE;
              ev      = EV_ERR;
            end
          end else if (is_dig) begin
            nxt.acc  = {60'd0, dig};
            nxt.mode = MODE_STRLEN;
          end else if (cur_i.depth != '0 && top_eff == ENT_DICT_KEY) begin
            nxt.err = ERR_KEY_TYPE;
            ev      = EV_ERR;
          end else if (byte_i == CH_I) begin
            nxt.acc  = '0;
            nxt.neg  = 1'b0;
            nxt.seen = 1'b0;
            nxt.mode = MODE_INT;
          end else if (byte_i == CH_L || byte_i == CH_D) begin
            if (cur_i.depth >= DEPTH_W'(MAX_DEPTH)) begin
              nxt.err = ERR_TOO_DEEP;
              ev      = EV_ERR;
            end else begin
              push_o    = 1'b1;
              nxt.top   = new_entry;
              nxt.depth = cur_i.depth + 6'd1;
              nxt.mode  = MODE_EXPECT;
              ev        = (byte_i == CH_D) ? EV_DOPEN : EV_LOPEN;
            end
          end else begin
            nxt.err = ERR_BAD_TYPE;
            ev      = EV_ERR;
          end
        end
        MODE_INT: begin
          if (byte_i == CH_MINUS) begin
            if (cur_i.seen || cur_i.neg) begin
              nxt.err = ERR_BAD_INT;
              ev      = EV_ERR;
            end else begin
              nxt.neg = 1'b1;
            end
          end else if (is_dig) begin
            if (!cur_i.seen) begin
              if (dig == 4'd0 && cur_i.neg) begin
                nxt.err = ERR_BAD_INT;
                ev      = EV_ERR;
              end else begin
                nxt.acc  = {60'd0, dig};
                nxt.seen = 1'b1;
              end
            end else if (cur_i.acc == '0) begin
              // leading zero
              nxt.err = ERR_BAD_INT;
              ev      = EV_ERR;
            end else if (over_int) begin
              nxt.err = ERR_INT_RNG;
              ev      = EV_ERR;
            end else begin
              nxt.acc = acc10[63:0];
            end
          end else if (byte_i == CH_E && cur_i.seen) begin
            ev       = EV_INT;
            val      = cur_i.neg ? 64'd0 - cur_i.acc : cur_i.acc;
            nxt.acc  = '0;
            nxt.neg  = 1'b0;
            nxt.seen = 1'b0;
            finish   = 1'b1;
          end else begin
            nxt.err = ERR_BAD_INT;
            ev      = EV_ERR;
          end
        end
        MODE_STRLEN: begin
          if (is_dig) begin
            if (over_len) begin
              nxt.err = ERR_BAD_LEN;
              ev      = EV_ERR;
            end else begin
              nxt.acc = acc10[63:0];
            end
          end else if (byte_i == CH_COLON) begin
            ev      = EV_HDR;
            val     = cur_i.acc;
            key     = key_ctx;
            nxt.rem = cur_i.acc[62:0];
            nxt.acc = '0;
            if (cur_i.acc == '0) begin
              finish = 1'b1;
            end else begin
              nxt.mode = MODE_STRDATA;
            end
          end else begin
            nxt.err = ERR_BAD_LEN;
            ev      = EV_ERR;
          end
        end
        MODE_STRDATA: begin
          ev      = EV_BYTE;
          val     = {56'd0, byte_i};
          key     = key_ctx;
          nxt.rem = rem_dec;
          finish  = (rem_dec == '0);
        end
        default: begin
          nxt.err = ERR_BAD_TYPE;
          ev      = EV_ERR;
        end
      endcase
    end

    // a finished scalar completes the top value or flips a dict's key phase
    if (finish) begin
      if (cur_i.depth == '0) begin
        nxt.top_done = 1'b1;
        nxt.mode     = MODE_DONE;
      end else begin
        nxt.top  = {cur_i.top[1] ^ cur_i.top[0], cur_i.top[0]};
        nxt.mode = MODE_EXPECT;
      end
    end

    if (last_i) begin
      if (nxt.err == ERR_NONE && !nxt.top_done) begin
        nxt.err = ERR_EARLY;
        ev      = EV_ERR;
      end
      ok = (nxt.err == ERR_NONE);
    end

    res_o.event_res  = ev;
    res_o.value      = (ev == EV_ERR) ? '0 : $signed(val);
    res_o.nest_depth = nxt.depth;
    res_o.is_key     = (ev == EV_HDR || ev == EV_BYTE) ? key : 1'b0;
    res_o.error_code = (ev == EV_ERR) ? nxt.err : ERR_NONE;
    res_o.message_ok = ok;

    // end of message: back to the reset state
    nxt_o = last_i ? ST_RESET : nxt;
  end

endmodule
